// File: sv/fpa_pkg.sv
package fpa_pkg;
	localparam int FRAC_BITS = 8;
	localparam int NW = 32 + FRAC_BITS;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_GT  = 4'd4;
	localparam logic [3:0] OP_LT  = 4'd5;
	localparam logic [3:0] OP_GE  = 4'd6;
	localparam logic [3:0] OP_LE  = 4'd7;
	localparam logic [3:0] OP_EQ  = 4'd8;
	localparam logic [3:0] OP_NE  = 4'd9;
	localparam logic [3:0] OP_MIN = 4'd10;
	localparam logic [3:0] OP_MAX = 4'd11;
	localparam logic [3:0] OP_INC = 4'd12;
	localparam logic [3:0] OP_DEC = 4'd13;
	localparam logic [3:0] OP_INT = 4'd14;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	typedef struct packed {
		logic [3:0]    cmd;
		logic          neg;
		logic [31:0]   res;
		logic          cmp;
		logic [1:0]    st;
		logic [63:0]   prod;
		logic [31:0]   d;
		logic [31:0]   rem;
		logic [NW-1:0] nq;
	} pipe_t;

	typedef struct packed {
		logic [31:0] res;
		logic        sat;
	} sat_t;

	function automatic sat_t sat_mag(input logic neg, input logic [63:0] m);
		sat_t r;
		r.sat = 1'b0;
		if (neg) begin
			if (m > 64'h8000_0000) begin
				r.res = 32'h8000_0000;
				r.sat = 1'b1;
			end else begin
				r.res = 32'(~m[31:0] + 32'd1);
			end
		end else begin
			if (m > 64'h7FFF_FFFF) begin
				r.res = 32'h7FFF_FFFF;
				r.sat = 1'b1;
			end else begin
				r.res = m[31:0];
			end
		end
		return r;
	endfunction
endpackage

// File: sv/fpa_front.sv
module fpa_front import fpa_pkg::*; (
	input  logic        clk,
	input  logic        adv,
	input  logic [3:0]  cmd,
	input  logic [31:0] a_raw,
	input  logic [31:0] b_raw,
	output pipe_t       p_s1
);
	logic signed [31:0] a, b;
	logic [31:0] ma, mb;
	logic signed [32:0] sum, dif, inc, dec;
	pipe_t p;

	assign a = a_raw;
	assign b = b_raw;

	always_comb begin
		ma = a[31] ? 32'(~a_raw + 32'd1) : a_raw;
		mb = b[31] ? 32'(~b_raw + 32'd1) : b_raw;
		sum = 33'(a) + 33'(b);
		dif = 33'(a) - 33'(b);
		inc = 33'(a) + 33'sd1;
		dec = 33'(a) - 33'sd1;
		p.cmd = cmd;
		p.neg = a[31] ^ b[31];
		p.res = '0;
		p.cmp = 1'b0;
		p.st = ST_OK;
		p.prod = {32'd0, ma} * {32'd0, mb};
		p.d = mb;
		p.rem = '0;
		p.nq = {ma, {FRAC_BITS{1'b0}}};
		unique case (cmd)
			OP_ADD: begin
				p.res = sum[31:0];
				if (sum[32] != sum[31]) begin
					p.res = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
					p.st = ST_SAT;
				end
			end
			OP_SUB: begin
				p.res = dif[31:0];
				if (dif[32] != dif[31]) begin
					p.res = dif[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
					p.st = ST_SAT;
				end
			end
			OP_INC: begin
				p.res = inc[31:0];
				if (inc[32] != inc[31]) begin
					p.res = 32'h7FFF_FFFF;
					p.st = ST_SAT;
				end
			end
			OP_DEC: begin
				p.res = dec[31:0];
				if (dec[32] != dec[31]) begin
					p.res = 32'h8000_0000;
					p.st = ST_SAT;
				end
			end
			OP_DIV: if (b_raw == '0) p.st = ST_DIV0;
			OP_GT:  p.cmp = a > b;
			OP_LT:  p.cmp = a < b;
			OP_GE:  p.cmp = a >= b;
			OP_LE:  p.cmp = a <= b;
			OP_EQ:  p.cmp = a == b;
			OP_NE:  p.cmp = a != b;
			OP_MIN: p.res = (a < b) ? a_raw : b_raw;
			OP_MAX: p.res = (a < b) ? b_raw : a_raw;
			OP_INT: p.res = 32'(a >>> FRAC_BITS);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) p_s1 <= p;
	end
endmodule

// File: sv/fpa_cell.sv
module fpa_cell import fpa_pkg::*; (
	input  logic  clk,
	input  logic  adv,
	input  pipe_t p_in,
	output pipe_t p_q
);
	logic [32:0] tr, diff;
	logic ge;
	pipe_t p;

	always_comb begin
		tr = {p_in.rem, p_in.nq[NW-1]};
		diff = tr - {1'b0, p_in.d};
		ge = tr >= {1'b0, p_in.d};
		p = p_in;
		p.rem = ge ? diff[31:0] : tr[31:0];
		p.nq = {p_in.nq[NW-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (adv) p_q <= p;
	end
endmodule

// File: sv/fpa_back.sv
module fpa_back import fpa_pkg::*; (
	input  logic        clk,
	input  logic        adv,
	input  pipe_t       p_in,
	output logic [31:0] result_q,
	output logic        cmp_q,
	output logic [1:0]  st_q
);
	logic [63:0] tm, qm, qd;
	logic up;
	sat_t sm, sd;
	logic [31:0] res;
	logic [1:0] st;

	always_comb begin
		tm = p_in.prod + (64'd1 << (FRAC_BITS - 1));
		qm = tm >> FRAC_BITS;
		up = {p_in.rem, 1'b0} >= {1'b0, p_in.d};
		qd = 64'(p_in.nq) + {63'd0, up};
		sm = sat_mag(p_in.neg, qm);
		sd = sat_mag(p_in.neg, qd);
		res = p_in.res;
		st = p_in.st;
		if (p_in.cmd == OP_MUL) begin
			res = sm.res;
			st = sm.sat ? ST_SAT : ST_OK;
		end else if (p_in.cmd == OP_DIV && p_in.st != ST_DIV0) begin
			res = sd.res;
			st = sd.sat ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= res;
			cmp_q <= p_in.cmp;
			st_q <= st;
		end
	end
endmodule

// File: sv/fixed_point_alu.sv
// Signed fixed-point ALU (FRAC_BITS fraction bits, 32-bit raw operands).
// One item per cycle while the result is taken; each item passes through a
// front register, the divider (a chain of 32+FRAC_BITS cells that each
// resolve one quotient bit) and a back register. All opcodes travel the
// same pipeline so results leave in order. The whole pipeline holds when
// the result is not taken.
module fixed_point_alu import fpa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  cmd,
	input  logic [31:0] a_raw,
	input  logic [31:0] b_raw,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_raw,
	output logic        compare_true,
	output logic [1:0]  status
);
	localparam int LAT = NW + 2;

	logic adv;
	logic [LAT-1:0] vld_q;
	pipe_t chain [NW+1];

	assign adv = !vld_q[LAT-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	fpa_front u_front (
		.clk(clk), .adv(adv), .cmd(cmd), .a_raw(a_raw), .b_raw(b_raw),
		.p_s1(chain[0])
	);

	for (genvar i = 0; i < NW; i++) begin : g_cell
		fpa_cell u_cell (.clk(clk), .adv(adv), .p_in(chain[i]), .p_q(chain[i+1]));
	end

	fpa_back u_back (
		.clk(clk), .adv(adv), .p_in(chain[NW]),
		.result_q(result_raw), .cmp_q(compare_true), .st_q(status)
	);
endmodule
